>>> sv/assert_macros.svh
// Assertion macros shared by the task watchdog RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> sv/wdg_pkg.sv
// Package for the multi-channel task watchdog: transaction kinds, state encoding,
// memory entry and result types. No dependencies.
package wdg_pkg;

    localparam int AGE_W = 16;
    localparam int CHAN_FIELD_W = 3;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_FEED   = 3'd1,
        KIND_CREATE = 3'd2,
        KIND_START  = 3'd3,
        KIND_STOP   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FEED_WR,
        ST_REPORT
    } state_t;

    // One channel record as held in the state memory.
    typedef struct packed {
        logic [AGE_W-1:0] timeout;
        logic [AGE_W-1:0] age;
    } entry_t;

    // Outcome of one tick sweep.
    typedef struct packed {
        logic                    kick;
        logic [CHAN_FIELD_W-1:0] failed_channel;
    } result_t;

endpackage

>>> sv/multi_channel_task_watchdog.sv
// Top level of the multi-channel task watchdog: sequencer, channel state memory and
// result register. Uses wdg_pkg, wdg_seq, wdg_mem and assert_macros.svh.
//
//  Channel   Ports                                  Direction  Moves
//  s_        s_valid s_ready s_kind s_channel s_timeout  in    tick/feed/create/start/stop
//  m_        m_valid m_ready m_kick m_failed_channel     out   one result per tick
//
// A tick is accepted, then sweeps the state memory (one read a cycle, the aged entry
// written back in the following cycle), then loads the result register when it is free.
// The single read port of the memory sets the sweep length.
// A feed reads the entry, then writes it back; create, start and stop act on acceptance.
// After reset the memory needs no clearing pass: a valid bit per entry makes unwritten
// entries read as zero. A stalled result holds the block only at the end of the next
// tick; other transactions are still taken while a result waits.
`include "assert_macros.svh"
module multi_channel_task_watchdog #(
    parameter int CHANNELS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_kind,
    input  logic [wdg_pkg::CHAN_FIELD_W-1:0] s_channel,
    input  logic [wdg_pkg::AGE_W-1:0]       s_timeout,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kick,
    output logic [wdg_pkg::CHAN_FIELD_W-1:0] m_failed_channel
);
    import wdg_pkg::*;

    // Channel index width; one bit even for a single channel.
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic             mem_re, mem_we;
    logic [IDX_W-1:0] mem_raddr, mem_waddr;
    entry_t           mem_rdata, mem_wdata;
    logic             out_free, res_load;
    result_t          res;
    logic             m_valid_reg, m_valid_next;
    result_t          m_res_reg, m_res_next;

    // The sequencer decodes each transaction and runs the sweep on a tick.
    wdg_seq #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_kind    (s_kind),
        .in_channel (s_channel),
        .in_timeout (s_timeout),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata)
    );

    // Ages and timeouts of all channels live in one memory.
    wdg_mem #(
        .DEPTH (CHANNELS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata)
    );

    // The result register is free when empty or when its transaction completes now.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_kick           = m_res_reg.kick;
    assign m_failed_channel = m_res_reg.failed_channel;

    `ASSERT_IMPLIES(a_kick_reports_zero, aclk, aresetn, m_valid_reg && m_kick,
        m_failed_channel == '0)
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, res_load, !m_valid_reg || m_ready)
    `ASSERT_NEXT(a_tick_busy, aclk, aresetn,
        s_valid && s_ready && s_kind == KIND_TICK, !s_ready)

endmodule

>>> sv/wdg_mem.sv
// Channel state memory: one write and one registered read port, with a valid bit per
// entry so that an entry never written reads as zero after reset. Uses wdg_pkg.
module wdg_mem #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                re,
    input  logic [IDX_W-1:0]    raddr,
    output wdg_pkg::entry_t     rdata,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  wdg_pkg::entry_t     wdata
);
    import wdg_pkg::*;

    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rdata_reg;
    logic               rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
            end
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

>>> sv/wdg_seq.sv
// Sequencer of the task watchdog: decodes transactions, sweeps the state memory on a
// tick and holds the active bits. Uses wdg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wdg_seq #(
    parameter int CHANNELS = 8,
    parameter int IDX_W    = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      in_kind,
    input  logic [wdg_pkg::CHAN_FIELD_W-1:0] in_channel,
    input  logic [wdg_pkg::AGE_W-1:0]       in_timeout,
    input  logic                            out_free,
    output logic                            res_load,
    output wdg_pkg::result_t                res,
    output logic                            mem_re,
    output logic [IDX_W-1:0]                mem_raddr,
    input  wdg_pkg::entry_t                 mem_rdata,
    output logic                            mem_we,
    output logic [IDX_W-1:0]                mem_waddr,
    output wdg_pkg::entry_t                 mem_wdata
);
    import wdg_pkg::*;

    localparam int CNT_W = $clog2(CHANNELS + 1);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        ch_reg, ch_next;
    logic                    dead_found_reg, dead_found_next;
    logic [CHAN_FIELD_W-1:0] dead_idx_reg, dead_idx_next;
    logic [CHANNELS-1:0]     active_reg, active_next;

    logic                    ch_ok;
    logic [IDX_W-1:0]        ch_idx;
    logic [AGE_W-1:0]        age_new;
    logic                    last_rd;

    assign ch_ok   = 32'(in_channel) < CHANNELS;
    assign ch_idx  = IDX_W'(in_channel);
    assign age_new = (mem_rdata.age == AGE_MAX) ? mem_rdata.age
                                                : mem_rdata.age + AGE_W'(1);
    assign last_rd = rd_vld_reg && (rd_idx_reg == IDX_W'(CHANNELS - 1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_kind == KIND_TICK) begin
                        state_next = ST_SWEEP;
                    end else if (in_kind == KIND_FEED && ch_ok) begin
                        state_next = ST_FEED_WR;
                    end
                end
            end
            ST_SWEEP: begin
                if (last_rd) begin
                    state_next = ST_REPORT;
                end
            end
            ST_FEED_WR: state_next = ST_IDLE;
            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        in_ready        = 1'b0;
        res_load        = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = '{timeout: mem_rdata.timeout, age: age_new};
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        ch_next         = ch_reg;
        dead_found_next = dead_found_reg;
        dead_idx_next   = dead_idx_reg;
        active_next     = active_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_kind)
                        KIND_TICK: begin
                            idx_next        = '0;
                            dead_found_next = 1'b0;
                            dead_idx_next   = '0;
                        end
                        KIND_FEED: begin
                            mem_re    = ch_ok;
                            mem_raddr = ch_idx;
                            ch_next   = ch_idx;
                        end
                        KIND_CREATE: begin
                            mem_we    = ch_ok;
                            mem_waddr = ch_idx;
                            mem_wdata = '{timeout: in_timeout, age: '0};
                        end
                        KIND_START: begin
                            if (ch_ok) begin
                                active_next[ch_idx] = 1'b1;
                            end
                        end
                        KIND_STOP: begin
                            if (ch_ok) begin
                                active_next[ch_idx] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                // Read one entry a cycle; the entry read last cycle is aged, checked and
                // written back in this one.
                if (idx_reg != CNT_W'(CHANNELS)) begin
                    mem_re      = 1'b1;
                    idx_next    = idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                end
                if (rd_vld_reg) begin
                    mem_we = 1'b1;
                    if (active_reg[rd_idx_reg] && !(age_new < mem_rdata.timeout)
                            && !dead_found_reg) begin
                        dead_found_next = 1'b1;
                        dead_idx_next   = CHAN_FIELD_W'(rd_idx_reg);
                    end
                end
            end
            ST_FEED_WR: begin
                mem_we    = 1'b1;
                mem_waddr = ch_reg;
                mem_wdata = '{timeout: mem_rdata.timeout, age: '0};
            end
            ST_REPORT: res_load = out_free;
            default: ;
        endcase
    end

    assign res.kick           = !dead_found_reg;
    assign res.failed_channel = dead_found_reg ? dead_idx_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_vld_reg     <= 1'b0;
            active_reg     <= '0;
            dead_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_vld_reg     <= rd_vld_next;
            active_reg     <= active_next;
            dead_found_reg <= dead_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        ch_reg       <= ch_next;
        dead_idx_reg <= dead_idx_next;
    end

    `ASSERT_IMPLIES(a_rd_only_when_busy, aclk, aresetn, rd_vld_reg, state_reg == ST_SWEEP)
    `ASSERT_IMPLIES(a_no_write_in_report, aclk, aresetn, state_reg == ST_REPORT, !mem_we)
    `ASSERT_NEXT(a_first_dead_kept, aclk, aresetn,
        dead_found_reg && state_reg == ST_SWEEP, dead_found_reg && $stable(dead_idx_reg))
    `ASSERT_NEXT(a_active_frozen_in_sweep, aclk, aresetn,
        state_reg == ST_SWEEP, $stable(active_reg))

endmodule
